// File: src/crfd_pkg.sv
package crfd_pkg;

   // Frame layout.
   localparam int unsigned FRAME_BYTES = 14;
   localparam int unsigned POS_W       = 4;
   localparam int unsigned ANGLE_FIRST = 4;
   localparam int unsigned SUM_LAST    = 12;
   localparam int unsigned ANGLE_COUNT = 9;
   localparam int unsigned ANGLE_W     = 19;
   localparam int unsigned MAG_W       = 18;

   localparam logic [7:0]       HDR_BYTE = 8'h68;
   localparam logic [POS_W-1:0] POS_HUNT = '0;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

   typedef logic [ANGLE_COUNT-1:0][7:0] angle_bytes_type;
   typedef logic [2:0][7:0]             angle_group_type;
   typedef logic signed [ANGLE_W-1:0]   angle_type;

   // Status of the byte currently being processed.
   typedef struct packed {
      logic frame_end;
      logic checksum_ok;
   } frame_status_type;

endpackage

// File: src/compass_response_frame_decoder_unit.sv
// Tilt-compass reply frame decoder.
// The req channel carries one received byte per item (req_rx_byte). The
// block hunts for the header byte, collects the thirteen further bytes of
// the frame and sums bytes one to twelve modulo 256.
// On the checksum byte one item leaves on the rsp channel: pitch, roll and
// heading in signed hundredths of a degree, and rsp_frame_ok set when the
// checksum matched. Other bytes produce no item.
// Throughput is one byte per cycle while req_ready is high. A byte goes into an
// input register and is processed there; the result register is loaded when
// a checksum byte leaves the input register, which raises rsp_valid.
// Reset (synchronous, active high) empties both registers and returns the
// block to header hunting.
// When the receiver stalls, the result register holds its item; bytes that
// produce no result keep flowing, and a further checksum byte waits in the
// input register, which drops req_ready until the result is taken.
module compass_response_frame_decoder_unit
   import crfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic [7:0] req_rx_byte,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output angle_type rsp_pitch_centideg,
   output angle_type rsp_roll_centideg,
   output angle_type rsp_heading_centideg,
   output logic      rsp_frame_ok
);

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             rsp_valid_ff;
   angle_type        pitch_ff, roll_ff, heading_ff;
   logic             ok_ff;
   logic             advance;
   angle_bytes_type  angle_bytes;
   frame_status_type status;
   angle_type        pitch, roll, heading;

   // The held item advances unless it produces a result that has no room.
   assign advance   = in_valid_ff && (!status.frame_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   crfd_frame_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .angle_bytes (angle_bytes),
      .status      (status)
   );

   crfd_angle_decode u_pitch (
      .group_bytes (angle_group_type'(angle_bytes[2:0])),
      .angle       (pitch)
   );

   crfd_angle_decode u_roll (
      .group_bytes (angle_group_type'(angle_bytes[5:3])),
      .angle       (roll)
   );

   crfd_angle_decode u_heading (
      .group_bytes (angle_group_type'(angle_bytes[8:6])),
      .angle       (heading)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && status.frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && status.frame_end) begin
         pitch_ff   <= pitch;
         roll_ff    <= roll;
         heading_ff <= heading;
         ok_ff      <= status.checksum_ok;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pitch_centideg   = pitch_ff;
   assign rsp_roll_centideg    = roll_ff;
   assign rsp_heading_centideg = heading_ff;
   assign rsp_frame_ok         = ok_ff;

endmodule

// File: src/crfd_angle_decode.sv
module crfd_angle_decode
   import crfd_pkg::*;
(
   input  angle_group_type group_bytes,
   output angle_type       angle
);

   logic [MAG_W-1:0] mag;
   logic             negative;

   // Each nibble keeps its place weight, including nibbles above nine.
   always_comb begin
      mag = MAG_W'(group_bytes[0][3:0]) * MAG_W'(10000)
          + MAG_W'(group_bytes[1][7:4]) * MAG_W'(1000)
          + MAG_W'(group_bytes[1][3:0]) * MAG_W'(100)
          + MAG_W'(group_bytes[2][7:4]) * MAG_W'(10)
          + MAG_W'(group_bytes[2][3:0]);
      negative = (group_bytes[0][7:4] != 4'd0);
   end

   // Any nonzero sign nibble negates; a zero magnitude stays zero.
   assign angle = negative ? -angle_type'({1'b0, mag}) : angle_type'({1'b0, mag});

endmodule

// File: src/crfd_frame_tracker.sv
module crfd_frame_tracker
   import crfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   output angle_bytes_type  angle_bytes,
   output frame_status_type status
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   angle_bytes_type  bytes_ff, bytes_in;
   logic             hunting;

   assign hunting = (pos_ff == POS_HUNT) || (pos_ff > POS_LAST);

   // Position, checksum and angle byte updates for one item.
   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      bytes_in = bytes_ff;
      if (hunting) begin
         if (rx_byte == HDR_BYTE) begin
            pos_in = POS_W'(1);
            sum_in = 8'd0;
         end else begin
            pos_in = POS_HUNT;
         end
      end else if (pos_ff == POS_LAST) begin
         pos_in = POS_HUNT;
      end else begin
         if (pos_ff <= POS_W'(SUM_LAST)) begin
            sum_in = sum_ff + rx_byte;
         end
         for (int i = 0; i < ANGLE_COUNT; i++) begin
            if (pos_ff == POS_W'(ANGLE_FIRST + i)) begin
               bytes_in[i] = rx_byte;
            end
         end
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Control state is reset; stored angle bytes are written before use.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= 8'd0;
      end else if (step) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         bytes_ff <= bytes_in;
      end
   end

   assign angle_bytes        = bytes_ff;
   assign status.frame_end   = !hunting && (pos_ff == POS_LAST);
   assign status.checksum_ok = (rx_byte == sum_ff);

endmodule

// File: sim/tb_compass_response_frame_decoder_unit.sv
module tb_compass_response_frame_decoder_unit
   import crfd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_BYTES    = 270;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 20;
   localparam int TIMEOUT_CYCLES = 300000;
   localparam int DIR_ROWS_N     = 30;

   // One decoded frame: three angles and the checksum flag.
   typedef struct packed {
      angle_type pitch;
      angle_type roll;
      angle_type heading;
      logic      ok;
   } attitude_type;

   // One row of the directed table: the byte, and a typed-in result where
   // the frame ends and the answer is plain to see.
   typedef struct packed {
      logic [7:0]   rx;
      logic         typed;
      attitude_type want;
   } dir_row_type;

   localparam attitude_type NO_RESULT = '0;

   localparam dir_row_type DIR_ROWS [DIR_ROWS_N] = '{
      // Noise while hunting: no item should come out.
      '{8'h00, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      // Header bytes as data, the largest positive angle, a negative zero
      // and the largest negative angle, with a good checksum.
      '{8'h68, 1'b0, NO_RESULT},
      '{8'h68, 1'b0, NO_RESULT},
      '{8'h68, 1'b0, NO_RESULT},
      '{8'h68, 1'b0, NO_RESULT},
      '{8'h0F, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hF0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h32, 1'b1, '{19'sd166665, 19'sd0, -19'sd166665, 1'b1}},
      // Ordinary BCD angles with a checksum that is one off.
      '{8'h68, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'h23, 1'b0, NO_RESULT},
      '{8'h45, 1'b0, NO_RESULT},
      '{8'h19, 1'b0, NO_RESULT},
      '{8'h99, 1'b0, NO_RESULT},
      '{8'h99, 1'b0, NO_RESULT},
      '{8'hB5, 1'b1, '{19'sd0, 19'sd12345, -19'sd99999, 1'b0}}
   };

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   angle_type  rsp_pitch_centideg;
   angle_type  rsp_roll_centideg;
   angle_type  rsp_heading_centideg;
   logic       rsp_frame_ok;

   // Shadow state of the decoder.
   logic [POS_W-1:0] frame_pos = POS_HUNT;
   logic [7:0]       frame_sum = 8'h00;
   logic [7:0]       angle_store [ANGLE_COUNT];

   attitude_type pending_attitudes [$];
   int           mismatch_count = 0;
   int           cycle_count    = 0;
   int           sent_in_phase  = 0;
   int           send_idle_pct  = 0;
   int           recv_idle_pct  = 0;
   int           hold_req       = 0;
   int           hold_left      = 0;

   compass_response_frame_decoder_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pitch_centideg   (rsp_pitch_centideg),
      .rsp_roll_centideg    (rsp_roll_centideg),
      .rsp_heading_centideg (rsp_heading_centideg),
      .rsp_frame_ok         (rsp_frame_ok)
   );

   // Clock, and a cycle counter that ends a hung run.
   initial begin
      forever begin
         #5 clock = ~clock;
         if (clock) begin
            cycle_count++;
            if (cycle_count >= TIMEOUT_CYCLES) begin
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   // Sign nibble plus five BCD digits, each nibble at its place weight.
   function automatic angle_type decode_bcd_angle(input logic [7:0] b0,
                                                  input logic [7:0] b1,
                                                  input logic [7:0] b2);
      int whole;
      int frac;
      int mag;
      whole = int'(b0[3:0]) * 100 + int'(b1[7:4]) * 10 + int'(b1[3:0]);
      frac  = int'(b2[7:4]) * 10 + int'(b2[3:0]);
      mag   = whole * 100 + frac;
      if (b0[7:4] != 4'h0) begin
         mag = -mag;
      end
      return angle_type'(mag);
   endfunction

   // Advances the shadow state by one byte; returns 1 when a frame ends.
   function automatic bit step_frame_byte(input logic [7:0] b, output attitude_type res);
      res = '0;
      if (frame_pos == POS_HUNT || frame_pos >= FRAME_BYTES) begin
         if (b == HDR_BYTE) begin
            frame_pos = POS_W'(1);
            frame_sum = 8'h00;
         end else begin
            frame_pos = POS_HUNT;
         end
         return 1'b0;
      end
      if (frame_pos == POS_LAST) begin
         res.pitch   = decode_bcd_angle(angle_store[0], angle_store[1], angle_store[2]);
         res.roll    = decode_bcd_angle(angle_store[3], angle_store[4], angle_store[5]);
         res.heading = decode_bcd_angle(angle_store[6], angle_store[7], angle_store[8]);
         res.ok      = (b == frame_sum);
         frame_pos   = POS_HUNT;
         return 1'b1;
      end
      if (frame_pos <= SUM_LAST) begin
         frame_sum = frame_sum + b;
      end
      if (frame_pos >= ANGLE_FIRST) begin
         angle_store[frame_pos - ANGLE_FIRST] = b;
      end
      frame_pos = frame_pos + POS_W'(1);
      return 1'b0;
   endfunction

   // Offers one byte, idling first at random, and waits until it is taken.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_ready !== 1'b1) begin
         @(posedge clock);
      end
   endtask

   task automatic offer_byte(input logic [7:0] b);
      attitude_type got;
      send_byte(b);
      if (step_frame_byte(b, got)) begin
         pending_attitudes.push_back(got);
      end
      sent_in_phase++;
   endtask

   // Stops offering and waits until every expected item has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_attitudes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // A frame with random content: mostly proper BCD angles and a good
   // checksum, sometimes raw bytes, a bad checksum or a cut-short frame.
   task automatic send_random_frame();
      logic [7:0] fb [FRAME_BYTES];
      logic [7:0] sum;
      logic [3:0] sign;
      int         base;
      int         n_bytes;
      fb[0] = HDR_BYTE;
      sum   = 8'h00;
      for (int i = 1; i < ANGLE_FIRST; i++) begin
         fb[i] = ($urandom_range(9) == 0) ? HDR_BYTE : 8'($urandom);
      end
      for (int g = 0; g < 3; g++) begin
         base = ANGLE_FIRST + 3 * g;
         sign = ($urandom_range(1) == 1) ? 4'($urandom_range(15, 1)) : 4'h0;
         if ($urandom_range(19) == 0) begin
            fb[base]     = {sign, 4'h0};
            fb[base + 1] = 8'h00;
            fb[base + 2] = 8'h00;
         end else if ($urandom_range(9) < 6) begin
            fb[base]     = {sign, 4'($urandom_range(9))};
            fb[base + 1] = {4'($urandom_range(9)), 4'($urandom_range(9))};
            fb[base + 2] = {4'($urandom_range(9)), 4'($urandom_range(9))};
         end else begin
            fb[base]     = 8'($urandom);
            fb[base + 1] = 8'($urandom);
            fb[base + 2] = 8'($urandom);
         end
      end
      for (int i = 1; i <= SUM_LAST; i++) begin
         sum = sum + fb[i];
      end
      fb[POS_LAST] = ($urandom_range(3) != 0) ? sum : 8'($urandom);
      n_bytes = ($urandom_range(9) == 0) ? $urandom_range(FRAME_BYTES - 1, 1) : FRAME_BYTES;
      for (int i = 0; i < n_bytes; i++) begin
         offer_byte(fb[i]);
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int hold);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      hold_req      = hold;
      sent_in_phase = 0;
      while (sent_in_phase < PHASE_BYTES) begin
         if ($urandom_range(9) < 8) begin
            send_random_frame();
         end else begin
            repeat ($urandom_range(3, 1)) offer_byte(8'($urandom));
         end
      end
      wait_drained();
   endtask

   // Result side: checks each item taken and picks the next ready level.
   task automatic check_attitude();
      attitude_type want;
      if (pending_attitudes.size() == 0) begin
         $error("rsp item arrived with no expected frame waiting");
         mismatch_count++;
         return;
      end
      want = pending_attitudes.pop_front();
      if (rsp_pitch_centideg !== want.pitch) begin
         $error("rsp_pitch_centideg: expected %0d, got %0d", want.pitch, rsp_pitch_centideg);
         mismatch_count++;
      end
      if (rsp_roll_centideg !== want.roll) begin
         $error("rsp_roll_centideg: expected %0d, got %0d", want.roll, rsp_roll_centideg);
         mismatch_count++;
      end
      if (rsp_heading_centideg !== want.heading) begin
         $error("rsp_heading_centideg: expected %0d, got %0d",
                want.heading, rsp_heading_centideg);
         mismatch_count++;
      end
      if (rsp_frame_ok !== want.ok) begin
         $error("rsp_frame_ok: expected %0b, got %0b", want.ok, rsp_frame_ok);
         mismatch_count++;
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            check_attitude();
         end
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Main sequence: reset, directed table, then three random phases.
   initial begin
      attitude_type got;
      bit           has_result;
      for (int i = 0; i < ANGLE_COUNT; i++) begin
         angle_store[i] = 8'h00;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS_N; r++) begin
         send_byte(DIR_ROWS[r].rx);
         has_result = step_frame_byte(DIR_ROWS[r].rx, got);
         if (DIR_ROWS[r].typed) begin
            pending_attitudes.push_back(DIR_ROWS[r].want);
         end else if (has_result) begin
            pending_attitudes.push_back(got);
         end
      end
      wait_drained();

      run_phase(15, 56, 0);
      run_phase(56, 15, 0);
      // No idling, but the receiver holds off long enough to back up the input.
      run_phase(0, 0, HOLD_CYCLES);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
